// ===== hdl/slat_pkg.sv =====
// ----------------------------------------------------------------------------
// slat_pkg
// Shared types and codes of the sensor lock / auto-move timer core.
// ----------------------------------------------------------------------------
package slat_pkg;

    // Configuration port geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SENSOR_MODE       = 3'd0;
    localparam logic [2:0] REG_LOCK_ENABLE       = 3'd1;
    localparam logic [2:0] REG_LOCK_TIME         = 3'd2;
    localparam logic [2:0] REG_AUTO_MOVE_TIME    = 3'd3;
    localparam logic [2:0] REG_TURN_ON_TIME      = 3'd4;
    localparam logic [2:0] REG_PROG_PORT_DISABLE = 3'd5;

    // Request codes
    localparam logic [1:0] REQ_TICK       = 2'd0;
    localparam logic [1:0] REQ_POLL       = 2'd1;
    localparam logic [1:0] REQ_CLEAR_PROG = 2'd2;

    // Switch command codes
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_CLOSE  = 2'd1;
    localparam logic [1:0] CMD_THROWN = 2'd2;
    localparam logic [1:0] CMD_TOGGLE = 2'd3;

    // Sensor mode codes
    localparam logic [2:0] MODE_OFF          = 3'd0;
    localparam logic [2:0] MODE_CLOSE_A      = 3'd1;
    localparam logic [2:0] MODE_CLOSE_B      = 3'd2;
    localparam logic [2:0] MODE_THROWN_A     = 3'd3;
    localparam logic [2:0] MODE_THROWN_B     = 3'd4;
    localparam logic [2:0] MODE_TOGGLE_A     = 3'd5;
    localparam logic [2:0] MODE_TOGGLE_B     = 3'd6;
    localparam logic [2:0] MODE_SENSOR_ONLY  = 3'd7;

    typedef struct packed {
        logic [2:0]  sensor_mode;
        logic        lock_enable;
        logic [15:0] lock_time;
        logic [15:0] auto_move_time;
        logic [15:0] turn_on_time;
        logic        prog_port_disable;
    } t_cfg;

    typedef struct packed {
        logic [1:0] req_type;
        logic       pin_level;
    } t_in_word;

    typedef struct packed {
        logic        prog_flag;
        logic        lock_status;
        logic [1:0]  switch_cmd;
        logic [15:0] drive_time;
    } t_out_word;

endpackage

// ===== hdl/slat_regs.sv =====
// ----------------------------------------------------------------------------
// slat_regs
// APB-style configuration register file.
// ----------------------------------------------------------------------------
module slat_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [slat_pkg::ADDR_W-1:0]  paddr,
    input  logic [slat_pkg::DATA_W-1:0]  pwdata,
    output logic [slat_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output slat_pkg::t_cfg               o_cfg
);

    slat_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                slat_pkg::REG_SENSOR_MODE:       r_cfg.sensor_mode       <= pwdata[2:0];
                slat_pkg::REG_LOCK_ENABLE:       r_cfg.lock_enable       <= pwdata[0];
                slat_pkg::REG_LOCK_TIME:         r_cfg.lock_time         <= pwdata[15:0];
                slat_pkg::REG_AUTO_MOVE_TIME:    r_cfg.auto_move_time    <= pwdata[15:0];
                slat_pkg::REG_TURN_ON_TIME:      r_cfg.turn_on_time      <= pwdata[15:0];
                slat_pkg::REG_PROG_PORT_DISABLE: r_cfg.prog_port_disable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            slat_pkg::REG_SENSOR_MODE:       prdata = {29'd0, r_cfg.sensor_mode};
            slat_pkg::REG_LOCK_ENABLE:       prdata = {31'd0, r_cfg.lock_enable};
            slat_pkg::REG_LOCK_TIME:         prdata = {16'd0, r_cfg.lock_time};
            slat_pkg::REG_AUTO_MOVE_TIME:    prdata = {16'd0, r_cfg.auto_move_time};
            slat_pkg::REG_TURN_ON_TIME:      prdata = {16'd0, r_cfg.turn_on_time};
            slat_pkg::REG_PROG_PORT_DISABLE: prdata = {31'd0, r_cfg.prog_port_disable};
            default:                         prdata = '0;
        endcase
    end

endmodule

// ===== hdl/slat_ctrl.sv =====
// ----------------------------------------------------------------------------
// slat_ctrl
// Timer state, per-word update logic and result register.
// ----------------------------------------------------------------------------
module slat_ctrl #(
    parameter logic [15:0] PROG_WINDOW_TICKS = 16'd200
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  slat_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  slat_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output slat_pkg::t_out_word  o_out_data
);

    logic [15:0] r_win_count, n_win_count;
    logic        r_prog_req,  n_prog_req;
    logic [15:0] r_lock_count, n_lock_count;
    logic [15:0] r_am_count,   n_am_count;
    logic        r_out_valid;
    slat_pkg::t_out_word r_out_data, n_out_data;

    logic        accept;
    logic [15:0] lk_load;
    logic [15:0] am_load;
    logic [1:0]  cmd;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_win_count  = r_win_count;
        n_prog_req   = r_prog_req;
        n_lock_count = r_lock_count;
        n_am_count   = r_am_count;
        cmd          = slat_pkg::CMD_NONE;
        lk_load      = r_lock_count;
        am_load      = r_am_count;

        case (i_in_data.req_type)
            slat_pkg::REQ_TICK: begin
                if (r_win_count != 16'd0)  n_win_count  = r_win_count - 16'd1;
                if (r_lock_count > 16'd1)  n_lock_count = r_lock_count - 16'd1;
                if (r_am_count > 16'd1)    n_am_count   = r_am_count - 16'd1;
            end
            slat_pkg::REQ_POLL: begin
                if (i_cfg.sensor_mode != slat_pkg::MODE_OFF) begin
                    // reload on a high sensor, stretch auto-move up to the lock time
                    if (i_in_data.pin_level) begin
                        if (i_cfg.lock_enable) lk_load = i_cfg.lock_time;
                        am_load = i_cfg.auto_move_time;
                        if (am_load < lk_load && am_load != 16'd0) am_load = lk_load;
                    end
                    n_lock_count = (lk_load == 16'd1) ? 16'd0 : lk_load;
                    n_am_count   = (am_load == 16'd1) ? 16'd0 : am_load;
                    if (am_load == 16'd1) begin
                        if (i_cfg.sensor_mode inside {slat_pkg::MODE_CLOSE_A,
                                                      slat_pkg::MODE_CLOSE_B}) begin
                            cmd = slat_pkg::CMD_CLOSE;
                        end else if (i_cfg.sensor_mode inside {slat_pkg::MODE_THROWN_A,
                                                               slat_pkg::MODE_THROWN_B}) begin
                            cmd = slat_pkg::CMD_THROWN;
                        end else if (i_cfg.sensor_mode inside {slat_pkg::MODE_TOGGLE_A,
                                                               slat_pkg::MODE_TOGGLE_B}) begin
                            cmd = slat_pkg::CMD_TOGGLE;
                        end
                    end
                end else if (r_win_count != 16'd0 && !i_cfg.prog_port_disable
                             && i_in_data.pin_level) begin
                    n_prog_req = 1'b1;
                end
            end
            slat_pkg::REQ_CLEAR_PROG: begin
                n_prog_req = 1'b0;
            end
            default: ;
        endcase

        n_out_data.prog_flag   = n_prog_req;
        n_out_data.lock_status = (i_cfg.sensor_mode != slat_pkg::MODE_OFF)
                                 && (n_lock_count != 16'd0);
        n_out_data.switch_cmd  = cmd;
        n_out_data.drive_time  = (cmd != slat_pkg::CMD_NONE) ? i_cfg.turn_on_time : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_count  <= PROG_WINDOW_TICKS;
            r_prog_req   <= 1'b0;
            r_lock_count <= 16'd0;
            r_am_count   <= 16'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_win_count  <= n_win_count;
                r_prog_req   <= n_prog_req;
                r_lock_count <= n_lock_count;
                r_am_count   <= n_am_count;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    // The program window only ever closes.
    a_win_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> r_win_count <= $past(r_win_count))
        else $error("program window count increased");

    // A pending command means the auto-move timer was just retired.
    a_cmd_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.switch_cmd != slat_pkg::CMD_NONE) |-> r_am_count == 16'd0)
        else $error("command issued with live auto-move timer");

    // Drive time travels only with a command.
    a_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.switch_cmd == slat_pkg::CMD_NONE)
        |-> r_out_data.drive_time == 16'd0)
        else $error("drive time without command");

    // Reported lock status tracks the stored lock timer.
    a_lock_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_data.lock_status ==
            ((i_cfg.sensor_mode != slat_pkg::MODE_OFF) && (r_lock_count != 16'd0)))
        else $error("lock status out of step with lock timer");

endmodule

// ===== hdl/sensor_lock_automove_timer_core.sv =====
// ----------------------------------------------------------------------------
// sensor_lock_automove_timer_core
// Sensor-driven lock and auto-move timer controller for a point motor.
// ----------------------------------------------------------------------------
// Each input word is a timer tick, a poll carrying the sampled pin level, or
// a request to clear the program flag, and each produces exactly one output
// word with the program flag, lock status and an optional switch command.
// One word is taken per clock unless a held output word drops o_in_ready:
// the update of all timers is a single layer of compares and 16-bit
// decrements between the timer registers and the output register, and
// o_out_valid rises in the cycle after acceptance. The output register
// holds a finished word while the next one is accepted whenever i_out_ready
// is high. Configuration lives behind an APB-style port at byte addresses
// 0x00..0x14 and is meant to be written only while no word is in flight.
// ----------------------------------------------------------------------------
module sensor_lock_automove_timer_core #(
    parameter logic [15:0] PROG_WINDOW_TICKS = 16'd200
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [slat_pkg::ADDR_W-1:0]  paddr,
    input  logic [slat_pkg::DATA_W-1:0]  pwdata,
    output logic [slat_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // input words
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  slat_pkg::t_in_word           i_in_data,
    // output words
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output slat_pkg::t_out_word          o_out_data
);

    // Configuration snapshot shared with the timer datapath
    slat_pkg::t_cfg cfg;

    // Register file: sensor mode, lock enable, lock/auto-move/turn-on times,
    // program pin disable. All reset to zero.
    slat_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Timer state and result register. Ticks count the program window down
    // to zero and the lock and auto-move timers down to one; polls in sensor
    // mode reload and retire the timers and issue the switch command.
    slat_ctrl #(
        .PROG_WINDOW_TICKS (PROG_WINDOW_TICKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor lock / auto-move timer core. A stimulus
// process queues input words phase by phase and reprograms the registers
// over APB while the core is idle. A clocked driver and a clocked monitor
// move the words. The monitor predicts every accepted word with a local
// timer model and compares each output word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    // Request code that the core must treat as a no-op
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [15:0] WINDOW_TICKS = 16'd200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------------
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [slat_pkg::ADDR_W-1:0] paddr = '0;
    logic [slat_pkg::DATA_W-1:0] pwdata = '0;
    logic [slat_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    slat_pkg::t_in_word          i_in_data = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    slat_pkg::t_out_word         o_out_data;

    always #6 i_clk = ~i_clk;

    sensor_lock_automove_timer_core #(
        .PROG_WINDOW_TICKS(WINDOW_TICKS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    slat_pkg::t_in_word  pending_words[$];    // words not yet offered to the core
    slat_pkg::t_out_word expected_status[$];  // predicted output words, oldest first

    int  words_sent = 0;     // words put on the input bus (driver)
    int  words_taken = 0;    // words accepted by the core (monitor)
    int  mismatches = 0;
    int  cycles = 0;
    bit  bursts_on = 1'b1;   // random idling on both sides

    // Shadow of the register file and of the timer state
    slat_pkg::t_cfg cfg_shadow = '0;
    logic [15:0]    window_cnt = WINDOW_TICKS;
    logic           prog_req = 1'b0;
    logic [15:0]    lock_cnt = '0;
    logic [15:0]    move_cnt = '0;

    // ------------------------------------------------------------------------
    // Timer model: apply one accepted word, return the status it produces
    // ------------------------------------------------------------------------
    function automatic slat_pkg::t_out_word advance_timers(slat_pkg::t_in_word w);
        slat_pkg::t_out_word st;
        logic [1:0]          cmd;
        cmd = slat_pkg::CMD_NONE;
        case (w.req_type)
            slat_pkg::REQ_TICK: begin
                // Window runs down to zero, lock and auto-move park at one
                if (window_cnt != 16'd0) window_cnt = window_cnt - 16'd1;
                if (lock_cnt > 16'd1) lock_cnt = lock_cnt - 16'd1;
                if (move_cnt > 16'd1) move_cnt = move_cnt - 16'd1;
            end
            slat_pkg::REQ_POLL: begin
                if (cfg_shadow.sensor_mode != slat_pkg::MODE_OFF) begin
                    if (w.pin_level) begin
                        // Sensor trigger: reload, stretch auto-move up to lock
                        if (cfg_shadow.lock_enable) lock_cnt = cfg_shadow.lock_time;
                        move_cnt = cfg_shadow.auto_move_time;
                        if (move_cnt < lock_cnt && move_cnt != 16'd0) move_cnt = lock_cnt;
                    end
                    // Retire timers parked at one
                    if (lock_cnt == 16'd1) lock_cnt = 16'd0;
                    if (move_cnt == 16'd1) begin
                        move_cnt = 16'd0;
                        case (cfg_shadow.sensor_mode)
                            slat_pkg::MODE_CLOSE_A,
                            slat_pkg::MODE_CLOSE_B:  cmd = slat_pkg::CMD_CLOSE;
                            slat_pkg::MODE_THROWN_A,
                            slat_pkg::MODE_THROWN_B: cmd = slat_pkg::CMD_THROWN;
                            slat_pkg::MODE_TOGGLE_A,
                            slat_pkg::MODE_TOGGLE_B: cmd = slat_pkg::CMD_TOGGLE;
                            default:                 cmd = slat_pkg::CMD_NONE;
                        endcase
                    end
                end else if (window_cnt != 16'd0 && !cfg_shadow.prog_port_disable
                             && w.pin_level) begin
                    prog_req = 1'b1;
                end
            end
            slat_pkg::REQ_CLEAR_PROG: prog_req = 1'b0;
            default: ;
        endcase
        st.prog_flag   = prog_req;
        st.lock_status = (cfg_shadow.sensor_mode != slat_pkg::MODE_OFF)
                         && (lock_cnt != 16'd0);
        st.switch_cmd  = cmd;
        st.drive_time  = (cmd != slat_pkg::CMD_NONE) ? cfg_shadow.turn_on_time : 16'd0;
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present words at the falling edge, hold until accepted
    // ------------------------------------------------------------------------
    int in_gap = 0;

    always @(negedge i_clk) begin
        // Hold valid and payload while the current word is outstanding
        if (words_sent == words_taken) begin
            if (in_gap != 0) begin
                in_gap = in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (bursts_on && pending_words.size() != 0
                         && $urandom_range(0, 11) == 0) begin
                // Start an idle burst, this one included
                in_gap = $urandom_range(1, 17) - 1;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                i_in_data  <= pending_words.pop_front();
                i_in_valid <= 1'b1;
                words_sent = words_sent + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off while the sender keeps
    // offering words, so the core backs up and drops o_in_ready
    // ------------------------------------------------------------------------
    int out_hold = 0;
    bit squeeze_done = 1'b0;

    always @(negedge i_clk) begin
        if (out_hold != 0) begin
            out_hold = out_hold - 1;
            i_out_ready <= 1'b0;
        end else if (!squeeze_done && pending_words.size() > 300) begin
            squeeze_done = 1'b1;
            out_hold = 199;
            i_out_ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 11) == 0) begin
            out_hold = $urandom_range(1, 17) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input acceptance, check on output acceptance
    // ------------------------------------------------------------------------
    task automatic report_bad(string what, slat_pkg::t_out_word want,
                              slat_pkg::t_out_word got);
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTS)
            $display({"tb_top: %s: exp flag=%0d lock=%0d cmd=%0d drive=%h,",
                      " got flag=%0d lock=%0d cmd=%0d drive=%h"},
                     what, want.prog_flag, want.lock_status, want.switch_cmd,
                     want.drive_time, got.prog_flag, got.lock_status,
                     got.switch_cmd, got.drive_time);
    endtask

    always @(posedge i_clk) begin
        slat_pkg::t_out_word want;
        if (i_rst_n) begin
            // Predict first so a word is queued before its result can show up
            if (i_in_valid && o_in_ready) begin
                expected_status.push_back(advance_timers(i_in_data));
                words_taken = words_taken + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_status.size() == 0) begin
                    report_bad("unexpected word", '0, o_out_data);
                end else begin
                    want = expected_status.pop_front();
                    if (want !== o_out_data) report_bad("mismatch", want, o_out_data);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // Register is written at this edge; mirror it in the shadow
        case (idx)
            slat_pkg::REG_SENSOR_MODE:       cfg_shadow.sensor_mode       = val[2:0];
            slat_pkg::REG_LOCK_ENABLE:       cfg_shadow.lock_enable       = val[0];
            slat_pkg::REG_LOCK_TIME:         cfg_shadow.lock_time         = val[15:0];
            slat_pkg::REG_AUTO_MOVE_TIME:    cfg_shadow.auto_move_time    = val[15:0];
            slat_pkg::REG_TURN_ON_TIME:      cfg_shadow.turn_on_time      = val[15:0];
            slat_pkg::REG_PROG_PORT_DISABLE: cfg_shadow.prog_port_disable = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_all(input logic [2:0] mode, input logic lock_en,
                               input logic [15:0] lock_t, input logic [15:0] move_t,
                               input logic [15:0] drive_t, input logic port_off);
        write_reg(slat_pkg::REG_SENSOR_MODE, {29'd0, mode});
        write_reg(slat_pkg::REG_LOCK_ENABLE, {31'd0, lock_en});
        write_reg(slat_pkg::REG_LOCK_TIME, {16'd0, lock_t});
        write_reg(slat_pkg::REG_AUTO_MOVE_TIME, {16'd0, move_t});
        write_reg(slat_pkg::REG_TURN_ON_TIME, {16'd0, drive_t});
        write_reg(slat_pkg::REG_PROG_PORT_DISABLE, {31'd0, port_off});
    endtask

    // Wait until every queued word has been accepted and answered
    task automatic drain();
        while (pending_words.size() != 0 || words_sent != words_taken
               || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_word(input logic [1:0] req, input logic pin);
        slat_pkg::t_in_word w;
        w.req_type  = req;
        w.pin_level = pin;
        pending_words.push_back(w);
    endtask

    // Single random word, mostly ticks and polls
    task automatic push_noise(input int tick_pct, input int pin_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < tick_pct)
            push_word(slat_pkg::REQ_TICK, 1'($urandom_range(0, 1)));
        else if (r < 90)
            push_word(slat_pkg::REQ_POLL, $urandom_range(0, 99) < pin_pct);
        else if (r < 97)
            push_word(slat_pkg::REQ_CLEAR_PROG, 1'($urandom_range(0, 1)));
        else
            push_word(REQ_UNUSED, 1'($urandom_range(0, 1)));
    endtask

    // Mostly trigger / count down / retire sequences, the rest noise
    task automatic fill_sensor_phase(input int n);
        int k;
        while (pending_words.size() < n) begin
            if ($urandom_range(0, 9) < 7) begin
                push_word(slat_pkg::REQ_POLL, 1'b1);
                k = $urandom_range(0, 14);
                repeat (k) begin
                    if ($urandom_range(0, 3) == 0) push_word(slat_pkg::REQ_POLL, 1'b0);
                    else push_word(slat_pkg::REQ_TICK, 1'($urandom_range(0, 1)));
                end
                push_word(slat_pkg::REQ_POLL, 1'b0);
            end else begin
                push_noise(45, 30);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    logic [2:0] phase_mode [8];
    int ph;

    initial begin
        phase_mode = '{slat_pkg::MODE_CLOSE_B, slat_pkg::MODE_THROWN_B,
                       slat_pkg::MODE_TOGGLE_A, slat_pkg::MODE_SENSOR_ONLY,
                       slat_pkg::MODE_CLOSE_A, slat_pkg::MODE_SENSOR_ONLY,
                       slat_pkg::MODE_THROWN_A, slat_pkg::MODE_TOGGLE_B};

        // Hold reset, then release it on a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Program entry while the window is open, registers at reset values
        push_word(slat_pkg::REQ_POLL, 1'b0);
        push_word(slat_pkg::REQ_POLL, 1'b1);
        push_word(REQ_UNUSED, 1'b1);
        push_word(REQ_UNUSED, 1'b0);
        push_word(slat_pkg::REQ_CLEAR_PROG, 1'b1);
        push_word(slat_pkg::REQ_TICK, 1'b1);
        drain();
        // Pin ignored when the program port is disabled
        write_reg(slat_pkg::REG_PROG_PORT_DISABLE, 32'd1);
        push_word(slat_pkg::REQ_POLL, 1'b1);
        drain();
        write_reg(slat_pkg::REG_PROG_PORT_DISABLE, 32'd0);
        push_word(slat_pkg::REQ_POLL, 1'b1);
        push_word(slat_pkg::REQ_CLEAR_PROG, 1'b0);
        drain();

        // Auto-move shorter than lock gets stretched; close after expiry
        program_all(slat_pkg::MODE_CLOSE_A, 1'b1, 16'd5, 16'd3, 16'hFFFF, 1'b0);
        push_word(slat_pkg::REQ_POLL, 1'b1);
        repeat (4) push_word(slat_pkg::REQ_TICK, 1'b0);
        push_word(slat_pkg::REQ_POLL, 1'b0);
        drain();
        // Auto-move of one expires on the trigger poll itself
        program_all(slat_pkg::MODE_SENSOR_ONLY, 1'b0, 16'd0, 16'd1, 16'h0001, 1'b0);
        push_word(slat_pkg::REQ_POLL, 1'b1);
        drain();
        write_reg(slat_pkg::REG_SENSOR_MODE, {29'd0, slat_pkg::MODE_TOGGLE_B});
        push_word(slat_pkg::REQ_POLL, 1'b1);
        drain();
        write_reg(slat_pkg::REG_SENSOR_MODE, {29'd0, slat_pkg::MODE_THROWN_A});
        push_word(slat_pkg::REQ_POLL, 1'b1);
        drain();

        // Sensor off: window closes after enough ticks, then pins are ignored.
        // The long receiver hold-off lands in this large phase.
        program_all(slat_pkg::MODE_OFF, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
        repeat (400) push_noise(60, 50);
        drain();

        // Random phases over the sensor modes, extremes in the sixth
        for (ph = 0; ph < 8; ph++) begin
            if (ph == 5)
                program_all(phase_mode[ph], 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
            else
                program_all(phase_mode[ph], 1'($urandom_range(0, 1)),
                            16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                            16'($urandom()), 1'($urandom_range(0, 1)));
            // No idling in the closing part of the run
            if (ph == 7) bursts_on = 1'b0;
            fill_sensor_phase(75);
            drain();
        end

        // Let the bench idle so that any stray word shows up
        repeat (10) @(posedge i_clk);
        if (expected_status.size() != 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
                $display("tb_top: %0d expected words never arrived", expected_status.size());
        end
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/slat_pkg.sv
hdl/slat_regs.sv
hdl/slat_ctrl.sv
hdl/sensor_lock_automove_timer_core.sv
verif/tb_top.sv
